>>> sv/thws_pkg.sv
// Shared types and constants for the task heartbeat watchdog supervisor.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none
package thws_pkg;

   localparam int TASKS      = 8;
   localparam int TASK_IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

   localparam int OP_W      = 2;
   localparam int TASK_ID_W = 3;
   localparam int REASON_W  = 4;
   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 32;
   localparam int MS_W      = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   // wide enough to compare any task_id against any task count
   localparam int ID_EXT_W  = 6;

   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_REQUIRE = 2'd1;
   localparam logic [OP_W-1:0] OP_KICK    = 2'd2;
   localparam logic [OP_W-1:0] OP_FAULT   = 2'd3;

   localparam logic [REASON_W-1:0] REASON_CPU_FIRST = 4'd1;
   localparam logic [REASON_W-1:0] REASON_CPU_LAST  = 4'd4;
   localparam logic [REASON_W-1:0] REASON_TIMEOUT   = 4'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE  = 2'd3;

   localparam logic [MS_W-1:0] PERIOD_RESET = 16'd250;
   localparam logic [MS_W-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [MS_W-1:0] GRACE_RESET  = 16'd3000;

   typedef struct packed {
      logic latch_item;  // capture the accepted word
      logic exec;        // apply the operation to the state
      logic walk_start;  // clear the stale flag, point at task 0
      logic walk_step;   // judge one task, advance
      logic finish;      // close a check that walked the tasks
      logic load_out;    // fill the result register
   } thws_cmd_type;

   typedef struct packed {
      logic out_free;    // result register empty or being taken
      logic check_due;   // current item is a tick that triggers a check
      logic in_grace;    // the check falls inside the startup grace
      logic walk_last;   // walk points at the last task
   } thws_status_type;

endpackage
`default_nettype wire

>>> sv/thws_ctrl.sv
// Sequencing controller for the heartbeat supervisor.
// Depends on thws_pkg; drives the datapath through command and status structs.
`default_nettype none
module thws_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire thws_pkg::thws_status_type status,
   output thws_pkg::thws_cmd_type         cmd
);
   import thws_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.check_due && !status.in_grace) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end else begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            cmd.load_out = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/thws_dp.sv
// Datapath of the heartbeat supervisor: registers, time base, stamps, log and result word.
// Depends on thws_pkg; steered by thws_ctrl.
`default_nettype none
module thws_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire thws_pkg::thws_cmd_type              cmd,
   output thws_pkg::thws_status_type                status,
   input  wire logic                                csr_we,
   input  wire logic [thws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [thws_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic [thws_pkg::OP_W-1:0]           req_op,
   input  wire logic [thws_pkg::TASK_ID_W-1:0]      req_task_id,
   input  wire logic [thws_pkg::REASON_W-1:0]       req_reason,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_refresh,
   output logic                                     rsp_timeout_found,
   output logic [thws_pkg::REASON_W-1:0]            rsp_recent_reason,
   output logic [thws_pkg::COUNT_W-1:0]             rsp_fault_tally,
   output logic [thws_pkg::COUNT_W-1:0]             rsp_timeout_count
);
   import thws_pkg::*;

   // configuration
   logic            enable_ff;
   logic [MS_W-1:0] period_ff;
   logic [MS_W-1:0] window_ff;
   logic [MS_W-1:0] grace_ff;

   // captured word
   logic [OP_W-1:0]      op_ff;
   logic [TASK_ID_W-1:0] id_ff;
   logic [REASON_W-1:0]  reason_ff;

   // supervisor state
   logic [TIME_W-1:0]   time_ff;
   logic [TIME_W-1:0]   time_in;
   logic [MS_W-1:0]     phase_ff;
   logic [MS_W-1:0]     phase_next;
   logic                phase_due;
   logic [TASKS-1:0]    mask_ff;
   logic [TIME_W-1:0]   stamp_ff [TASKS];
   logic [REASON_W-1:0] reason_store_ff;
   logic [REASON_W-1:0] reason_store_in;
   logic [COUNT_W-1:0]  fault_ff;
   logic [COUNT_W-1:0]  fault_in;
   logic [COUNT_W-1:0]  timeout_ff;
   logic [COUNT_W-1:0]  timeout_in;

   // check walk
   logic [TASK_IDX_W-1:0] walk_idx_ff;
   logic                  stale_ff;
   logic [TIME_W-1:0]     walk_stamp;
   logic [TIME_W-1:0]     walk_age;
   logic                  walk_stale;

   // result register
   logic                rsp_valid_ff;
   logic                out_refresh_ff;
   logic                out_timeout_ff;
   logic [REASON_W-1:0] out_reason_ff;
   logic [COUNT_W-1:0]  out_faults_ff;
   logic [COUNT_W-1:0]  out_timeouts_ff;

   logic [ID_EXT_W-1:0]   id_ext;
   logic [TASK_IDX_W-1:0] id_idx;
   logic                  id_in_range;
   logic                  is_tick;
   logic                  log_en;
   logic [REASON_W-1:0]   log_code;

   assign id_ext      = {{(ID_EXT_W-TASK_ID_W){1'b0}}, id_ff};
   assign id_idx      = id_ext[TASK_IDX_W-1:0];
   assign id_in_range = id_ext < ID_EXT_W'(TASKS);
   assign is_tick     = (op_ff == OP_TICK);

   assign time_in    = time_ff + TIME_W'(1);
   assign phase_next = phase_ff + MS_W'(1);
   assign phase_due  = phase_next >= period_ff;

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.check_due = is_tick && phase_due && enable_ff;
   assign status.in_grace  = time_in < {{(TIME_W-MS_W){1'b0}}, grace_ff};
   assign status.walk_last = walk_idx_ff == TASK_IDX_W'(TASKS-1);

   // a never-kicked stamp of zero is stale as well
   assign walk_stamp = stamp_ff[walk_idx_ff];
   assign walk_age   = time_ff - walk_stamp;
   assign walk_stale = mask_ff[walk_idx_ff] &&
                       ((walk_stamp == '0) ||
                        (walk_age > {{(TIME_W-MS_W){1'b0}}, window_ff}));

   // fault log: a report, or a timeout closing a failed check
   always_comb begin
      log_en   = 1'b0;
      log_code = reason_ff;
      if (cmd.exec && (op_ff == OP_FAULT)) begin
         log_en = 1'b1;
      end else if (cmd.finish && stale_ff) begin
         log_en   = 1'b1;
         log_code = REASON_TIMEOUT;
      end
   end

   always_comb begin
      reason_store_in = reason_store_ff;
      fault_in        = fault_ff;
      timeout_in      = timeout_ff;
      if (log_en) begin
         reason_store_in = log_code;
         if ((log_code >= REASON_CPU_FIRST) && (log_code <= REASON_CPU_LAST)) begin
            fault_in = fault_ff + COUNT_W'(1);
         end else if (log_code == REASON_TIMEOUT) begin
            timeout_in = timeout_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         period_ff <= PERIOD_RESET;
         window_ff <= WINDOW_RESET;
         grace_ff  <= GRACE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_PERIOD: period_ff <= csr_wdata;
            CSR_WINDOW: window_ff <= csr_wdata;
            CSR_GRACE:  grace_ff  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         op_ff     <= req_op;
         id_ff     <= req_task_id;
         reason_ff <= req_reason;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         phase_ff        <= '0;
         mask_ff         <= '0;
         reason_store_ff <= '0;
         fault_ff        <= '0;
         timeout_ff      <= '0;
      end else begin
         reason_store_ff <= reason_store_in;
         fault_ff        <= fault_in;
         timeout_ff      <= timeout_in;
         if (cmd.exec && is_tick) begin
            time_ff  <= time_in;
            phase_ff <= phase_due ? '0 : phase_next;
         end
         if (cmd.exec && (op_ff == OP_REQUIRE) && id_in_range) begin
            mask_ff[id_idx] <= 1'b1;
         end
      end
   end

   // stamps are read only under a set mask bit, and setting it writes the stamp
   always_ff @(posedge clock) begin
      if (cmd.exec && ((op_ff == OP_REQUIRE) || (op_ff == OP_KICK)) && id_in_range) begin
         stamp_ff[id_idx] <= time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         walk_idx_ff <= '0;
         stale_ff    <= 1'b0;
      end else if (cmd.walk_step) begin
         walk_idx_ff <= walk_idx_ff + TASK_IDX_W'(1);
         stale_ff    <= stale_ff || walk_stale;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_refresh_ff  <= cmd.finish ? !stale_ff : status.check_due;
         out_timeout_ff  <= cmd.finish && stale_ff;
         out_reason_ff   <= reason_store_in;
         out_faults_ff   <= fault_in;
         out_timeouts_ff <= timeout_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_refresh       = out_refresh_ff;
   assign rsp_timeout_found = out_timeout_ff;
   assign rsp_recent_reason = out_reason_ff;
   assign rsp_fault_tally   = out_faults_ff;
   assign rsp_timeout_count = out_timeouts_ff;

endmodule
`default_nettype wire

>>> sv/task_heartbeat_watchdog_supervisor_unit.sv
// Task heartbeat watchdog supervisor: controller and datapath.
// Usage:
//   req_* carries one word: a 1 ms tick, a task require, a task kick or a
//   fault report. rsp_* returns exactly one result word per request word,
//   in order: refresh and timeout flags of a check plus the fault log.
//   csr_* writes the enable, check period, heartbeat window and startup
//   grace registers; write only while no request is in flight.
// Sequencing:
//   A request is accepted only when the supervisor is idle. A word that does
//   not start a task walk is executed in the state after acceptance, and its
//   result is then registered in the output register. A tick that triggers
//   a check outside the startup grace walks the task stamps one task per
//   cycle, then a finish state loads its result. The next word is taken only
//   after the previous one has loaded its result.
// Reset and stall:
//   Reset clears the time base, phase, mask and log, and loads the register
//   defaults (disabled, 250, 1000, 3000 ms). A result waits in the output
//   register while rsp_ready is low; one further request may be accepted as
//   soon as that register is being emptied.
`default_nettype none
module task_heartbeat_watchdog_supervisor_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [thws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [thws_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [thws_pkg::OP_W-1:0]        req_op,
   input  wire logic [thws_pkg::TASK_ID_W-1:0]   req_task_id,
   input  wire logic [thws_pkg::REASON_W-1:0]    req_reason,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_refresh,
   output logic                                  rsp_timeout_found,
   output logic [thws_pkg::REASON_W-1:0]         rsp_recent_reason,
   output logic [thws_pkg::COUNT_W-1:0]          rsp_fault_tally,
   output logic [thws_pkg::COUNT_W-1:0]          rsp_timeout_count
);
   import thws_pkg::*;

   thws_cmd_type    cmd;
   thws_status_type status;

   thws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   thws_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_op            (req_op),
      .req_task_id       (req_task_id),
      .req_reason        (req_reason),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_refresh       (rsp_refresh),
      .rsp_timeout_found (rsp_timeout_found),
      .rsp_recent_reason (rsp_recent_reason),
      .rsp_fault_tally   (rsp_fault_tally),
      .rsp_timeout_count (rsp_timeout_count)
   );

endmodule
`default_nettype wire

>>> sv/thws_checker.sv
// Port-level checks for the heartbeat supervisor, bound to the top level.
// Depends on thws_pkg for port widths and the timeout reason code.
`default_nettype none
module thws_props (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             rsp_refresh,
   input  wire logic                             rsp_timeout_found,
   input  wire logic [thws_pkg::REASON_W-1:0]    rsp_recent_reason,
   input  wire logic [thws_pkg::COUNT_W-1:0]     rsp_fault_tally,
   input  wire logic [thws_pkg::COUNT_W-1:0]     rsp_timeout_count
);
   import thws_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_refresh) &&
      $stable(rsp_timeout_found) && $stable(rsp_recent_reason) &&
      $stable(rsp_fault_tally) && $stable(rsp_timeout_count))
      else $error("result word changed while stalled");

   // one word in flight: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_refresh && rsp_timeout_found))
      else $error("refresh and timeout in one result");

   a_timeout_logged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timeout_found |-> rsp_recent_reason == REASON_TIMEOUT)
      else $error("timeout found but not logged");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind task_heartbeat_watchdog_supervisor_unit thws_props u_thws_props (.*);
`default_nettype wire

>>> bench/thws_checker.sv
`timescale 1ns / 100ps
// Port checker for the task heartbeat watchdog supervisor: watches the csr,
// request and result ports, predicts each result word and compares it.
// Depends on thws_pkg for widths, operation, reason and register codes.
module thws_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [thws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [thws_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [thws_pkg::OP_W-1:0]       req_op,
   input  logic [thws_pkg::TASK_ID_W-1:0]  req_task_id,
   input  logic [thws_pkg::REASON_W-1:0]   req_reason,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_refresh,
   input  logic                            rsp_timeout_found,
   input  logic [thws_pkg::REASON_W-1:0]   rsp_recent_reason,
   input  logic [thws_pkg::COUNT_W-1:0]    rsp_fault_tally,
   input  logic [thws_pkg::COUNT_W-1:0]    rsp_timeout_count,
   output int                              errors,
   output int                              outstanding
);
   import thws_pkg::*;

   typedef struct packed {
      logic                refresh;
      logic                timeout_found;
      logic [REASON_W-1:0] recent_reason;
      logic [COUNT_W-1:0]  fault_tally;
      logic [COUNT_W-1:0]  timeout_count;
   } verdict_type;

   verdict_type due_verdicts[$];
   int fail_tally = 0;
   int backlog = 0;

   // register copies
   logic            en_r;
   logic [MS_W-1:0] period_r;
   logic [MS_W-1:0] window_r;
   logic [MS_W-1:0] grace_r;

   // supervisor state
   logic [TIME_W-1:0]   now_ms;
   logic [MS_W-1:0]     phase_ms;
   logic [TASKS-1:0]    required;
   logic [TIME_W-1:0]   stamp [TASKS];
   logic [REASON_W-1:0] reason_r;
   logic [COUNT_W-1:0]  cpu_faults;
   logic [COUNT_W-1:0]  sup_timeouts;

   assign errors      = fail_tally;
   assign outstanding = backlog;

   function void record_reason(input logic [REASON_W-1:0] code);
      reason_r = code;
      if (code >= REASON_CPU_FIRST && code <= REASON_CPU_LAST) begin
         cpu_faults = cpu_faults + COUNT_W'(1);
      end else if (code == REASON_TIMEOUT) begin
         sup_timeouts = sup_timeouts + COUNT_W'(1);
      end
   endfunction

   // a stamp of zero means the task never kicked
   function bit tasks_alive();
      logic [TIME_W-1:0] age;
      for (int t = 0; t < TASKS; t++) begin
         age = now_ms - stamp[t];
         if (required[t] && (stamp[t] == '0 || age > TIME_W'(window_r))) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function verdict_type supervise_word(input logic [OP_W-1:0]      op,
                                        input logic [TASK_ID_W-1:0] id,
                                        input logic [REASON_W-1:0]  why);
      verdict_type v;
      v = '0;
      case (op)
         OP_TICK: begin
            now_ms   = now_ms + TIME_W'(1);
            phase_ms = phase_ms + MS_W'(1);
            if (phase_ms >= period_r) begin
               phase_ms = '0;
               if (en_r) begin
                  if (now_ms < TIME_W'(grace_r) || tasks_alive()) begin
                     v.refresh = 1'b1;
                  end else begin
                     v.timeout_found = 1'b1;
                     record_reason(REASON_TIMEOUT);
                  end
               end
            end
         end
         OP_REQUIRE, OP_KICK: begin
            if (int'(id) < TASKS) begin
               stamp[id] = now_ms;
               if (op == OP_REQUIRE) begin
                  required[id] = 1'b1;
               end
            end
         end
         OP_FAULT: record_reason(why);
         default: ;
      endcase
      v.recent_reason = reason_r;
      v.fault_tally   = cpu_faults;
      v.timeout_count = sup_timeouts;
      return v;
   endfunction

   function void check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         en_r     = 1'b0;
         period_r = PERIOD_RESET;
         window_r = WINDOW_RESET;
         grace_r  = GRACE_RESET;
         now_ms   = '0;
         phase_ms = '0;
         required = '0;
         for (int t = 0; t < TASKS; t++) begin
            stamp[t] = '0;
         end
         reason_r     = '0;
         cpu_faults   = '0;
         sup_timeouts = '0;
         due_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE: en_r     = csr_wdata[0];
               CSR_PERIOD: period_r = csr_wdata;
               CSR_WINDOW: window_r = csr_wdata;
               CSR_GRACE:  grace_r  = csr_wdata;
               default: ;
            endcase
         end
         // take the result before pushing, so a word accepted now never matches it
         if (rsp_valid && rsp_ready) begin
            if (due_verdicts.size() == 0) begin
               $error("result word arrived with nothing expected");
               fail_tally++;
            end else begin
               want = due_verdicts.pop_front();
               check_field("refresh", COUNT_W'(want.refresh), COUNT_W'(rsp_refresh));
               check_field("timeout_found", COUNT_W'(want.timeout_found),
                           COUNT_W'(rsp_timeout_found));
               check_field("recent_reason", COUNT_W'(want.recent_reason),
                           COUNT_W'(rsp_recent_reason));
               check_field("fault_tally", want.fault_tally, rsp_fault_tally);
               check_field("timeout_count", want.timeout_count, rsp_timeout_count);
            end
         end
         if (req_valid && req_ready) begin
            due_verdicts.push_back(supervise_word(req_op, req_task_id, req_reason));
         end
      end
      backlog = due_verdicts.size();
   end

endmodule

>>> bench/tb_task_heartbeat_watchdog_supervisor_unit.sv
`timescale 1ns / 100ps
// Top of the supervisor testbench: clock, reset, stimulus and verdict.
// Depends on thws_pkg, the supervisor unit and the thws_checker module.
module tb_task_heartbeat_watchdog_supervisor_unit;
   import thws_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int SETTLE_TICKS = TASKS + 6;

   // reason codes the package does not name
   localparam logic [REASON_W-1:0] REASON_NONE      = 4'd0;
   localparam logic [REASON_W-1:0] REASON_ERR_HNDLR = 4'd6;
   localparam logic [REASON_W-1:0] REASON_UNUSED    = 4'd15;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op = OP_TICK;
   logic [TASK_ID_W-1:0]  req_task_id = '0;
   logic [REASON_W-1:0]   req_reason = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_refresh;
   logic                  rsp_timeout_found;
   logic [REASON_W-1:0]   rsp_recent_reason;
   logic [COUNT_W-1:0]    rsp_fault_tally;
   logic [COUNT_W-1:0]    rsp_timeout_count;
   int                    errors;
   int                    outstanding;

   bit calm = 1'b0;
   int ticks_sent = 0;

   task_heartbeat_watchdog_supervisor_unit dut (.*);
   thws_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 14);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send(input logic [OP_W-1:0] op, input logic [TASK_ID_W-1:0] id,
                       input logic [REASON_W-1:0] why);
      int gap;
      if (!calm && $urandom_range(99) < 14) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_task_id <= id;
      req_reason  <= why;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_TICK) begin
         ticks_sent++;
      end
      @(negedge clock);
   endtask

   // hold off until every result word is back and the unit has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic set_regs(input bit en, input logic [MS_W-1:0] period,
                           input logic [MS_W-1:0] window, input logic [MS_W-1:0] grace);
      logic [CSR_DATA_W-1:0] en_word;
      drain();
      // only bit 0 of the enable register counts; scramble the rest
      en_word    = CSR_DATA_W'($urandom);
      en_word[0] = en;
      write_reg(CSR_ENABLE, en_word);
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_WINDOW, window);
      write_reg(CSR_GRACE, grace);
      csr_we <= 1'b0;
   endtask

   task automatic random_words(input int count);
      int pick;
      logic [OP_W-1:0] op;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 48) begin
            op = OP_TICK;
         end else if (pick < 58) begin
            op = OP_REQUIRE;
         end else if (pick < 86) begin
            op = OP_KICK;
         end else begin
            op = OP_FAULT;
         end
         send(op, TASK_ID_W'($urandom), REASON_W'($urandom));
         if ($urandom_range(79) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults, disabled: a require and a kick at time zero count as never kicked
      send(OP_REQUIRE, 3'd0, REASON_NONE);
      send(OP_KICK, 3'd7, REASON_NONE);
      send(OP_FAULT, 3'd0, REASON_CPU_FIRST);
      send(OP_FAULT, 3'd0, REASON_CPU_LAST);
      send(OP_FAULT, 3'd0, REASON_TIMEOUT);
      send(OP_FAULT, 3'd0, REASON_ERR_HNDLR);
      send(OP_FAULT, 3'd0, REASON_UNUSED);
      send(OP_FAULT, 3'd0, REASON_NONE);
      send(OP_TICK, 3'd0, REASON_NONE);
      send(OP_TICK, 3'd0, REASON_NONE);

      // check on every tick, zero window, no grace
      set_regs(1'b1, 16'd1, 16'd0, 16'd0);
      send(OP_TICK, 3'd0, REASON_NONE);
      send(OP_KICK, 3'd0, REASON_NONE);
      send(OP_REQUIRE, 3'd7, REASON_NONE);
      send(OP_TICK, 3'd0, REASON_NONE);

      // zero period, widest window
      set_regs(1'b1, 16'd0, 16'hFFFF, 16'd0);
      send(OP_TICK, 3'd0, REASON_NONE);
      send(OP_TICK, 3'd0, REASON_NONE);

      // stale tasks, but inside the widest grace
      set_regs(1'b1, 16'd1, 16'd0, 16'hFFFF);
      send(OP_TICK, 3'd0, REASON_NONE);
      send(OP_TICK, 3'd0, REASON_NONE);

      set_regs(1'b1, 16'd3, 16'd12, 16'd0);
      random_words(90);
      set_regs(1'b1, 16'd1, MS_W'($urandom_range(4, 10)), 16'd0);
      random_words(80);
      set_regs(1'b0, 16'd2, 16'd10, 16'd0);
      random_words(50);
      set_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
      random_words(40);
      set_regs(1'b1, 16'd0, 16'd8, 16'd0);
      random_words(60);
      // grace runs out partway through this stretch
      set_regs(1'b1, 16'd4, 16'hFFFF, MS_W'(ticks_sent + 30));
      random_words(90);
      calm <= 1'b1;
      set_regs(1'b1, 16'd5, 16'd20, 16'd0);
      random_words(80);
      calm <= 1'b0;
      set_regs(1'b1, 16'd2, 16'd0, 16'd0);
      random_words(40);

      drain();
      if (errors == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/thws_pkg.sv
sv/thws_ctrl.sv
sv/thws_dp.sv
sv/task_heartbeat_watchdog_supervisor_unit.sv
sv/thws_checker.sv
bench/thws_checker.sv
bench/tb_task_heartbeat_watchdog_supervisor_unit.sv
